// ----- sv/mal_pkg.sv -----
// ----------------------------------------------------------------------------
// mal_pkg
// Shared constants, codes and types of the MAC allow-list table core.
// ----------------------------------------------------------------------------
package mal_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Field widths
  localparam int MAC_W    = 48;
  localparam int TYPE_W   = 8;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  // Stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_FIELDS_W  = OP_W + MAC_W + TYPE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + TYPE_W + MAC_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = MAC_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_PRESET_ENABLE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PRESET_MAC    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PRESET_TYPE   = 2'd2;

  // Command opcodes
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_FIND   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_MAC  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

// ----- sv/mac_allow_list_table_core.sv -----
// ----------------------------------------------------------------------------
// mac_allow_list_table_core
// Table of approved MAC addresses with device types and a configurable preset
// peer. Lookup, add, remove, find-by-type and clear commands are served by one
// entry comparator that steps through the slots under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake         Payload
//  in_      slave      tvalid / tready   tdata: opcode, peer_mac, peer_type
//  out_     master     tvalid / tready   tdata: status, found_type, found_mac
//  cfg_     write      cfg_we            cfg_addr, cfg_wdata
//
//  A command passes through the idle state, where the input transfer happens,
//  the scan state, which steps through every slot with the shared comparator,
//  and the done state, which settles the result and applies the table update;
//  the next input transfer waits until the command is back in the idle state.
//  rst_n is synchronous, active low; it empties the table and clears the preset.
//  A result waiting on out_tready does not block the next input transfer; a
//  second result holds in the finish cycle until the output register frees.
// ----------------------------------------------------------------------------
module mac_allow_list_table_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [mal_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [mal_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // Command stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mal_pkg::IN_TDATA_W-1:0]      in_tdata,   // [2:0] opcode, [50:3] peer_mac,
                                                          // [58:51] peer_type
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mal_pkg::OUT_TDATA_W-1:0]     out_tdata   // [1:0] status, [9:2] found_type,
                                                          // [57:10] found_mac
);

  import mal_pkg::*;

  // Configuration registers
  logic              preset_en_r;
  logic [MAC_W-1:0]  preset_mac_r;
  logic [TYPE_W-1:0] preset_type_r;

  // Table storage
  logic [TABLE_ENTRIES-1:0] entry_valid_r, entry_valid_nxt;
  logic [MAC_W-1:0]         entry_mac_r  [TABLE_ENTRIES];
  logic [TYPE_W-1:0]        entry_type_r [TABLE_ENTRIES];

  // Sequencer and command registers
  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [MAC_W-1:0]  mac_r, mac_nxt;
  logic [TYPE_W-1:0] type_r, type_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic              free_r, free_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [TYPE_W-1:0] hit_type_r, hit_type_nxt;
  logic [MAC_W-1:0]  hit_mac_r, hit_mac_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Table write strobes
  logic              wr_mac_en;
  logic              wr_type_en;
  logic [IDX_W-1:0]  wr_idx;

  // Datapath signals
  logic              preset_active;
  logic              cmp_hit;
  logic              last_slot;
  logic              out_free;
  logic              finish;
  logic [STATUS_W-1:0] res_status;
  logic [TYPE_W-1:0] res_type;
  logic [MAC_W-1:0]  res_mac;

  assign preset_active = preset_en_r && (preset_mac_r != '0);
  assign last_slot     = (idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign out_free      = !out_valid_r || out_tready;
  assign finish        = (state_r == S_DONE) && out_free;

  // Shared entry comparator: type match for find, address match otherwise
  always_comb begin
    if (op_r == OP_FIND) begin
      cmp_hit = entry_valid_r[idx_r] && (entry_type_r[idx_r] == type_r);
    end else begin
      cmp_hit = entry_valid_r[idx_r] && (entry_mac_r[idx_r] == mac_r);
    end
  end

  // Settle the result of the scanned command
  always_comb begin
    res_status = ST_NOT_FOUND;
    res_type   = '0;
    res_mac    = '0;
    case (op_r)
      OP_LOOKUP: begin
        if (mac_r == '0) begin
          res_status = ST_NOT_FOUND;
        end else if (preset_active && (preset_mac_r == mac_r)) begin
          res_status = ST_OK;
          res_type   = preset_type_r;
        end else if (hit_r) begin
          res_status = ST_OK;
          res_type   = hit_type_r;
        end
      end
      OP_ADD: begin
        if (mac_r == '0) begin
          res_status = ST_ZERO_MAC;
        end else if (hit_r || free_r) begin
          res_status = ST_OK;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit_r) begin
          res_status = ST_OK;
        end
      end
      OP_FIND: begin
        if (preset_active && (preset_type_r == type_r)) begin
          res_status = ST_OK;
          res_mac    = preset_mac_r;
        end else if (hit_r) begin
          res_status = ST_OK;
          res_mac    = hit_mac_r;
        end
      end
      OP_CLEAR: begin
        res_status = ST_OK;
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    mac_nxt         = mac_r;
    type_nxt        = type_r;
    idx_nxt         = idx_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    hit_type_nxt    = hit_type_r;
    hit_mac_nxt     = hit_mac_r;
    entry_valid_nxt = entry_valid_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    wr_mac_en       = 1'b0;
    wr_type_en      = 1'b0;
    wr_idx          = hit_idx_r;

    // Drop the result once transferred
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = op_t'(in_tdata[OP_W-1:0]);
          mac_nxt   = in_tdata[OP_W +: MAC_W];
          type_nxt  = in_tdata[OP_W+MAC_W +: TYPE_W];
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Keep the first matching slot and the first free slot
        if (cmp_hit && !hit_r) begin
          hit_nxt      = 1'b1;
          hit_idx_nxt  = idx_r;
          hit_type_nxt = entry_type_r[idx_r];
          hit_mac_nxt  = entry_mac_r[idx_r];
        end
        if (!entry_valid_r[idx_r] && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (last_slot) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), res_mac, res_type, res_status};
          state_nxt     = S_IDLE;
          // Apply the table update
          case (op_r)
            OP_ADD: begin
              if (mac_r != '0) begin
                if (hit_r) begin
                  wr_type_en = 1'b1;
                  wr_idx     = hit_idx_r;
                end else if (free_r) begin
                  wr_type_en = 1'b1;
                  wr_mac_en  = 1'b1;
                  wr_idx     = free_idx_r;
                  entry_valid_nxt[free_idx_r] = 1'b1;
                end
              end
            end
            OP_REMOVE: begin
              if (hit_r) begin
                entry_valid_nxt[hit_idx_r] = 1'b0;
              end
            end
            OP_CLEAR: begin
              entry_valid_nxt = '0;
            end
            default: begin
              entry_valid_nxt = entry_valid_r;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_valid_r <= '0;
      out_valid_r   <= 1'b0;
      preset_en_r   <= 1'b0;
      preset_mac_r  <= '0;
      preset_type_r <= '0;
    end else begin
      state_r       <= state_nxt;
      entry_valid_r <= entry_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PRESET_ENABLE: preset_en_r   <= cfg_wdata[0];
          CFG_PRESET_MAC:    preset_mac_r  <= cfg_wdata[MAC_W-1:0];
          CFG_PRESET_TYPE:   preset_type_r <= cfg_wdata[TYPE_W-1:0];
          default: begin
            preset_en_r <= preset_en_r;
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    mac_r      <= mac_nxt;
    type_r     <= type_nxt;
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    hit_type_r <= hit_type_nxt;
    hit_mac_r  <= hit_mac_nxt;
    out_data_r <= out_data_nxt;
  end

  // Table entry storage
  always_ff @(posedge clk) begin
    if (wr_mac_en) begin
      entry_mac_r[wr_idx] <= mac_r;
    end
    if (wr_type_en) begin
      entry_type_r[wr_idx] <= type_r;
    end
  end

  // Checks
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_SCAN) && (idx_r == '0))
    else $error("scan did not start at slot zero after a transfer");

  a_hit_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN || state_r == S_DONE) && hit_r) |-> entry_valid_r[hit_idx_r])
    else $error("recorded match points at an invalid slot");

  a_full_means_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && (res_status == ST_FULL)) |-> (&entry_valid_r))
    else $error("table full reported with a free slot");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && (op_r == OP_CLEAR)) |=> (entry_valid_r == '0))
    else $error("clear left valid slots");

endmodule
